/* sv/acpl_pkg.sv */
// ----------------------------------------------------------------------------
// acpl_pkg
// Shared types and constants of the average-cost position ledger: table
// geometry, field widths and the request and response payload structs.
// ----------------------------------------------------------------------------
package acpl_pkg;

   // instrument table geometry
   localparam int INSTRUMENTS = 256;
   localparam int ADDR_W      = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;

   // field widths
   localparam int IDX_W   = 8;
   localparam int QTY_W   = 32;
   localparam int PRICE_W = 40;
   localparam int MONEY_W = 64;
   localparam int ENTRY_W = QTY_W + PRICE_W;

   // shared multiplier: quantity times half a price per pass
   localparam int HALF_W = PRICE_W / 2;
   localparam int PROD_W = QTY_W + PRICE_W;
   localparam int WIDE_W = MONEY_W + 10;

   // restoring divider: one quotient bit per cycle
   localparam int DIV_STEPS = PRICE_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int DVS_W     = QTY_W + 1;

   typedef struct packed {
      logic [IDX_W-1:0]          instrument;
      logic signed [QTY_W-1:0]   fill_quantity;
      logic [PRICE_W-1:0]        fill_price;
   } req_type;

   typedef struct packed {
      logic signed [QTY_W-1:0]   position_quantity;
      logic [PRICE_W-1:0]        average_cost;
      logic signed [MONEY_W-1:0] cash_balance;
      logic signed [MONEY_W-1:0] realized_profit;
      logic                      saturated;
   } rsp_type;

endpackage

/* sv/average_cost_position_ledger_core.sv */
// ----------------------------------------------------------------------------
// average_cost_position_ledger_core
// Average-cost position ledger: per-instrument quantity and cost table, cash
// and realized profit, updated by one fill request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   A fill request (req_data) is taken at a clock edge where start is high
//   and busy is low. busy stays high while the fill is worked on.
//   One response per request appears on rsp_data for exactly one cycle,
//   marked by rsp_valid; the receiver has no way to stall it.
//   Path from accept to rsp_valid: a fill into a flat position goes through
//   LOAD, a multiply and CASH to FIN; an out-of-range instrument goes to FIN
//   at once; a fill against the position adds a multiply and PNL; a fill that
//   adds to it adds a multiply, NUM and the steps of the restoring divider for
//   the weighted average cost, one quotient bit per cycle over 40 bits; the
//   products go through one shared 32x20 multiplier, two passes per product.
//   A new request can be taken in the cycle the response is shown.
//   The table lives in a RAM; a valid bit per entry makes a cleared entry
//   read as zero, so no clearing pass is needed.
//   Reset clears the table, cash and profit. A csr_wr_en write loads cash
//   with csr_wr_data, zeroes profit and clears the table; write only while
//   busy is low.
// ----------------------------------------------------------------------------
module average_cost_position_ledger_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  acpl_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output acpl_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [acpl_pkg::MONEY_W-1:0]  csr_wr_data
);
   import acpl_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_LOAD   = 9'b000000010,
      ST_MUL_LO = 9'b000000100,
      ST_MUL_HI = 9'b000001000,
      ST_CASH   = 9'b000010000,
      ST_NUM    = 9'b000100000,
      ST_DIV    = 9'b001000000,
      ST_PNL    = 9'b010000000,
      ST_FIN    = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      PH_CASH,
      PH_NUM,
      PH_PNL
   } phase_type;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   req_type               req_ff, req_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  skip_ff, skip_in;
   logic                  sat_ff, sat_in;
   logic [QTY_W-1:0]      prev_ff, prev_in;
   logic [PRICE_W-1:0]    cost_ff, cost_in;
   logic [QTY_W-1:0]      mul_a_ff, mul_a_in;
   logic [PRICE_W-1:0]    mul_b_ff, mul_b_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  gain_ff, gain_in;
   logic [DVS_W-1:0]      dvs_ff, dvs_in;
   logic [DVS_W-1:0]      rem_ff, rem_in;
   logic [PRICE_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [MONEY_W-1:0]    cash_ff, cash_in;
   logic [MONEY_W-1:0]    profit_ff, profit_in;
   logic [INSTRUMENTS-1:0] valid_ff, valid_in;

   logic                  ram_we;
   logic [ENTRY_W-1:0]    ram_wr_data;
   logic [ENTRY_W-1:0]    ram_rd_data;
   logic [ADDR_W-1:0]     ram_rd_addr;

   logic [QTY_W+HALF_W-1:0] mul_p;
   logic [QTY_W-1:0]      q_bits;
   logic [QTY_W-1:0]      aq;
   logic [QTY_W-1:0]      ap;
   logic [QTY_W:0]        nq;
   logic                  in_range;

   // signed money sum, saturated to 64 bits; top bit is the saturation flag
   function automatic logic [MONEY_W:0] sat_money(input logic [WIDE_W-1:0] x);
      logic fits;
      fits = (&x[WIDE_W-1:MONEY_W-1]) | ~(|x[WIDE_W-1:MONEY_W-1]);
      if (fits) begin
         return {1'b0, x[MONEY_W-1:0]};
      end else if (x[WIDE_W-1]) begin
         return {1'b1, 1'b1, {(MONEY_W-1){1'b0}}};
      end else begin
         return {1'b1, 1'b0, {(MONEY_W-1){1'b1}}};
      end
   endfunction

   // table storage: quantity over cost
   acpl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (INSTRUMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_addr = ADDR_W'(req_data.instrument);
   assign in_range    = 32'(req_data.instrument) < 32'(INSTRUMENTS);

   // magnitudes and new quantity
   assign q_bits = req_ff.fill_quantity;
   assign aq     = q_bits[QTY_W-1] ? (~q_bits + 1'b1) : q_bits;
   assign ap     = prev_ff[QTY_W-1] ? (~prev_ff + 1'b1) : prev_ff;
   assign nq     = {prev_ff[QTY_W-1], prev_ff} + {q_bits[QTY_W-1], q_bits};

   // shared multiplier: one half of the price operand per pass
   assign mul_p = mul_a_ff * ((state_ff == ST_MUL_HI) ? mul_b_ff[PRICE_W-1:HALF_W]
                                                        : mul_b_ff[HALF_W-1:0]);

   // sequencer and datapath next state
   always_comb begin
      logic [WIDE_W-1:0]  wide_sum;
      logic [MONEY_W:0]   sat_res;
      logic [PROD_W-1:0]  num;
      logic [DVS_W:0]     r2;
      logic               ge;
      logic               up;
      logic [QTY_W-1:0]   nq_sat;
      logic               q_sat;
      logic [PRICE_W-1:0] cost_fin;

      state_in     = state_ff;
      phase_in     = phase_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      addr_in      = addr_ff;
      skip_in      = skip_ff;
      sat_in       = sat_ff;
      prev_in      = prev_ff;
      cost_in      = cost_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      gain_in      = gain_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      cash_in      = cash_ff;
      profit_in    = profit_ff;
      valid_in     = valid_ff;
      ram_we       = 1'b0;
      ram_wr_data  = '0;
      wide_sum     = '0;
      sat_res      = '0;
      num          = '0;
      r2           = '0;
      ge           = 1'b0;
      up           = 1'b0;
      nq_sat       = '0;
      q_sat        = 1'b0;
      cost_fin     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               addr_in  = ADDR_W'(req_data.instrument);
               skip_in  = !in_range;
               sat_in   = 1'b0;
               state_in = in_range ? ST_LOAD : ST_FIN;
            end
         end
         // table entry arrives; a cleared entry reads as zero
         ST_LOAD: begin
            prev_in  = valid_ff[addr_ff] ? ram_rd_data[ENTRY_W-1:PRICE_W] : '0;
            cost_in  = valid_ff[addr_ff] ? ram_rd_data[PRICE_W-1:0] : '0;
            mul_a_in = aq;
            mul_b_in = req_ff.fill_price;
            phase_in = PH_CASH;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            acc_in   = PROD_W'(mul_p);
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            acc_in = acc_ff + (PROD_W'(mul_p) << HALF_W);
            case (phase_ff)
               PH_CASH: state_in = ST_CASH;
               PH_NUM:  state_in = ST_NUM;
               PH_PNL:  state_in = ST_PNL;
               default: state_in = ST_IDLE;
            endcase
         end
         // cash update and branch on the position direction
         ST_CASH: begin
            wide_sum = q_bits[QTY_W-1]
                     ? {{(WIDE_W-MONEY_W){cash_ff[MONEY_W-1]}}, cash_ff} + WIDE_W'(acc_ff)
                     : {{(WIDE_W-MONEY_W){cash_ff[MONEY_W-1]}}, cash_ff} - WIDE_W'(acc_ff);
            sat_res  = sat_money(wide_sum);
            cash_in  = sat_res[MONEY_W-1:0];
            sat_in   = sat_ff | sat_res[MONEY_W];
            prod_in  = acc_ff;
            if (prev_ff == '0) begin
               cost_in  = req_ff.fill_price;
               state_in = ST_FIN;
            end else if ((q_bits != '0) && (q_bits[QTY_W-1] == prev_ff[QTY_W-1])) begin
               mul_a_in = ap;
               mul_b_in = cost_ff;
               dvs_in   = DVS_W'(ap) + DVS_W'(aq);
               phase_in = PH_NUM;
               state_in = ST_MUL_LO;
            end else begin
               up       = req_ff.fill_price >= cost_ff;
               mul_a_in = (aq < ap) ? aq : ap;
               mul_b_in = up ? (req_ff.fill_price - cost_ff) : (cost_ff - req_ff.fill_price);
               gain_in  = prev_ff[QTY_W-1] ? !up : up;
               phase_in = PH_PNL;
               state_in = ST_MUL_LO;
            end
         end
         // numerator of the weighted cost, divider setup
         ST_NUM: begin
            num      = acc_ff + prod_ff;
            rem_in   = {1'b0, num[PROD_W-1:PRICE_W]};
            quo_in   = num[PRICE_W-1:0];
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         // one restoring division step
         ST_DIV: begin
            r2     = {rem_ff, quo_ff[PRICE_W-1]};
            ge     = r2 >= {1'b0, dvs_ff};
            rem_in = ge ? DVS_W'(r2 - {1'b0, dvs_ff}) : r2[DVS_W-1:0];
            quo_in = {quo_ff[PRICE_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cost_in  = quo_in;
               state_in = ST_FIN;
            end
         end
         // realized profit on the closed quantity
         ST_PNL: begin
            wide_sum = gain_ff
                     ? {{(WIDE_W-MONEY_W){profit_ff[MONEY_W-1]}}, profit_ff} + WIDE_W'(acc_ff)
                     : {{(WIDE_W-MONEY_W){profit_ff[MONEY_W-1]}}, profit_ff} - WIDE_W'(acc_ff);
            sat_res   = sat_money(wide_sum);
            profit_in = sat_res[MONEY_W-1:0];
            sat_in    = sat_ff | sat_res[MONEY_W];
            if ((nq != '0) && (nq[QTY_W] != prev_ff[QTY_W-1])) begin
               cost_in = req_ff.fill_price;
            end
            state_in = ST_FIN;
         end
         // quantity clamp, table write and response
         ST_FIN: begin
            if (nq[QTY_W] != nq[QTY_W-1]) begin
               q_sat  = 1'b1;
               nq_sat = nq[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
            end else begin
               nq_sat = nq[QTY_W-1:0];
            end
            cost_fin    = (nq == '0) ? '0 : cost_ff;
            ram_we      = !skip_ff;
            ram_wr_data = {nq_sat, cost_fin};
            if (!skip_ff) begin
               valid_in[addr_ff] = 1'b1;
            end
            rsp_in.position_quantity = skip_ff ? '0 : nq_sat;
            rsp_in.average_cost      = skip_ff ? '0 : cost_fin;
            rsp_in.cash_balance      = cash_ff;
            rsp_in.realized_profit   = profit_ff;
            rsp_in.saturated         = sat_ff | (q_sat & !skip_ff);
            rsp_valid_in             = 1'b1;
            state_in                 = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // ledger reload on a capital write
      if (csr_wr_en) begin
         cash_in   = csr_wr_data;
         profit_in = '0;
         valid_in  = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         cash_ff      <= '0;
         profit_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         cash_ff      <= cash_in;
         profit_ff    <= profit_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      addr_ff  <= addr_in;
      skip_ff  <= skip_in;
      sat_ff   <= sat_in;
      prev_ff  <= prev_in;
      cost_ff  <= cost_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      gain_ff  <= gain_in;
      dvs_ff   <= dvs_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a response follows every finish step, and is shown only after one
   a_rsp_after_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |=> rsp_valid)
      else $error("response strobe missing after finish step");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < CNT_W'(DIV_STEPS)))
      else $error("divider step count out of range");
`endif

endmodule

/* sv/acpl_ram.sv */
// ----------------------------------------------------------------------------
// acpl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module acpl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
